// File: hdl/kwrm_pkg.sv
// Shared types and constants of the k-way run merger.
// Command layout between the front decoder, the command queue and the merge engine.
// No dependencies.
package kwrm_pkg;

   localparam int MASK_W      = 8;
   localparam int WAY_W       = 3;
   localparam int VALUE_W     = 32;
   localparam int QUEUE_DEPTH = 2;

   // Codes of the request type field.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_HEAD  = 1'b1;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_DELIVER = 2'd1,
      CMD_DROP    = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [MASK_W-1:0]         mask;
      logic [WAY_W-1:0]          way;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } cmd_type;

   // Front to queue: one transfer into the queue.
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_push_type;

   // Queue to merge engine: the oldest queued command.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

endpackage

// File: hdl/kwrm_front.sv
// Front decoder: accepts request transfers and classifies them into commands.
// Depends on kwrm_pkg; feeds kwrm_cmd_queue.
module kwrm_front #(
   parameter int MAX_WAYS = 8
) (
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_type,
   input  logic [kwrm_pkg::MASK_W-1:0]               req_active_mask,
   input  logic [kwrm_pkg::WAY_W-1:0]                req_way,
   input  logic signed [kwrm_pkg::VALUE_W-1:0]       req_head_value,
   input  logic                                      req_last_in_run,
   input  logic                                      q_full,
   output kwrm_pkg::q_push_type                      q_push
);
   import kwrm_pkg::*;

   cmd_kind_type kind;

   always_comb begin
      if (req_type == REQ_START) begin
         kind = CMD_START;
      end else if (int'(req_way) < MAX_WAYS) begin
         kind = CMD_DELIVER;
      end else begin
         // A head for a way the engine does not have is dropped.
         kind = CMD_DROP;
      end
   end

   assign req_stall        = q_full;
   assign q_push.push      = req_valid && !q_full;
   assign q_push.cmd.kind  = kind;
   assign q_push.cmd.mask  = req_active_mask;
   assign q_push.cmd.way   = req_way;
   assign q_push.cmd.value = req_head_value;
   assign q_push.cmd.last  = req_last_in_run;

endmodule

// File: hdl/kwrm_cmd_queue.sv
// Short command queue that decouples the front decoder from the merge engine.
// Depends on kwrm_pkg.
module kwrm_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  kwrm_pkg::q_push_type q_push,
   output logic                 q_full,
   input  logic                 q_pop,
   output kwrm_pkg::q_head_type q_head
);
   import kwrm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign q_full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign q_head.valid = (cnt_ff != '0);
   assign q_head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push      = q_push.push;
   assign do_pop       = q_pop && q_head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("command queue count beyond depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("command queue count missed a push");

endmodule

// File: hdl/kwrm_back.sv
// Merge engine: keeps the per-way heads, runs the minimum tree and drives results.
// Depends on kwrm_pkg; takes commands from kwrm_cmd_queue.
module kwrm_back #(
   parameter int MAX_WAYS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kwrm_pkg::q_head_type                q_head,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [kwrm_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [kwrm_pkg::WAY_W-1:0]          rsp_from_way,
   output logic                                rsp_refill_needed,
   output logic                                rsp_run_done,
   output logic                                rsp_dummy_run,
   output logic                                rsp_last_of_burst
);
   import kwrm_pkg::*;

   localparam int IDX_W  = $clog2(MAX_WAYS);
   localparam int LEAVES = 1 << IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } back_state_type;

   back_state_type               state_ff, state_in;
   logic signed [VALUE_W-1:0]    heads_ff [MAX_WAYS];
   logic [MAX_WAYS-1:0]          valid_ff, valid_in;
   logic [MAX_WAYS-1:0]          last_ff, last_in;
   logic [MAX_WAYS-1:0]          wait_ff, wait_in;

   logic                         out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0]    out_value_ff, out_value_in;
   logic [WAY_W-1:0]             out_way_ff, out_way_in;
   logic                         out_refill_ff, out_refill_in;
   logic                         out_done_ff, out_done_in;
   logic                         out_dummy_ff, out_dummy_in;
   logic                         out_lob_ff, out_lob_in;

   logic                         slot_free;
   logic                         load;
   logic                         head_we;
   logic [MAX_WAYS-1:0]          start_mask;
   logic [MAX_WAYS-1:0]          way_hit;
   logic [MAX_WAYS-1:0]          min_hot;
   logic                         min_done;

   logic                         node_valid [2*LEAVES];
   logic signed [VALUE_W-1:0]    node_value [2*LEAVES];
   logic [IDX_W-1:0]             node_idx   [2*LEAVES];

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && q_head.valid && slot_free;

   // Decode of the queued command into per-way vectors.
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < MASK_W) begin
            start_mask[w] = q_head.cmd.mask[3'(w)];
            way_hit[w]    = (q_head.cmd.way == 3'(w));
         end else begin
            start_mask[w] = 1'b0;
            way_hit[w]    = 1'b0;
         end
      end
   end

   // Minimum tree over the registered live heads; on equal values the lower way wins.
   always_comb begin
      node_valid[0] = 1'b0;
      node_value[0] = '0;
      node_idx[0]   = '0;
      for (int w = 0; w < LEAVES; w++) begin
         if (w < MAX_WAYS) begin
            node_valid[LEAVES + w] = valid_ff[w];
            node_value[LEAVES + w] = heads_ff[w];
         end else begin
            node_valid[LEAVES + w] = 1'b0;
            node_value[LEAVES + w] = '0;
         end
         node_idx[LEAVES + w] = IDX_W'(w);
      end
      for (int i = LEAVES - 1; i >= 1; i--) begin
         if (node_valid[2*i+1] &&
             (!node_valid[2*i] || (node_value[2*i+1] < node_value[2*i]))) begin
            node_valid[i] = 1'b1;
            node_value[i] = node_value[2*i+1];
            node_idx[i]   = node_idx[2*i+1];
         end else begin
            node_valid[i] = node_valid[2*i];
            node_value[i] = node_value[2*i];
            node_idx[i]   = node_idx[2*i];
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         min_hot[w] = node_valid[1] && (node_idx[1] == IDX_W'(w));
      end
   end

   assign min_done = ((valid_ff & ~min_hot) == '0);

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      last_in       = last_ff;
      wait_in       = wait_ff;
      head_we       = 1'b0;
      load          = 1'b0;
      out_value_in  = out_value_ff;
      out_way_in    = out_way_ff;
      out_refill_in = out_refill_ff;
      out_done_in   = out_done_ff;
      out_dummy_in  = out_dummy_ff;
      out_lob_in    = out_lob_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               unique case (q_head.cmd.kind)
                  CMD_START: begin
                     // A start abandons any merge in progress.
                     valid_in = '0;
                     last_in  = '0;
                     wait_in  = start_mask;
                     if (start_mask == '0) begin
                        load          = 1'b1;
                        out_value_in  = '0;
                        out_way_in    = '0;
                        out_refill_in = 1'b0;
                        out_done_in   = 1'b0;
                        out_dummy_in  = 1'b1;
                        out_lob_in    = 1'b1;
                     end
                  end
                  CMD_DELIVER: begin
                     if ((way_hit & wait_ff) != '0) begin
                        head_we  = 1'b1;
                        valid_in = valid_ff | way_hit;
                        last_in  = q_head.cmd.last ? (last_ff | way_hit) : (last_ff & ~way_hit);
                        wait_in  = wait_ff & ~way_hit;
                        if ((wait_ff & ~way_hit) == '0) begin
                           state_in = ST_EMIT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (node_valid[1]) begin
                  load          = 1'b1;
                  valid_in      = valid_ff & ~min_hot;
                  out_value_in  = node_value[1];
                  out_way_in    = 3'(node_idx[1]);
                  out_dummy_in  = 1'b0;
                  if ((last_ff & min_hot) != '0) begin
                     // The way's run has ended: retire it and keep emitting unless no live head is left.
                     last_in       = last_ff & ~min_hot;
                     out_refill_in = 1'b0;
                     out_done_in   = min_done;
                     out_lob_in    = min_done;
                     if (min_done) begin
                        state_in = ST_IDLE;
                     end
                  end else begin
                     wait_in       = wait_ff | min_hot;
                     out_refill_in = 1'b1;
                     out_done_in   = 1'b0;
                     out_lob_in    = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (slot_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         last_ff      <= '0;
         wait_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         last_ff      <= last_in;
         wait_ff      <= wait_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (head_we && way_hit[w]) begin
            heads_ff[w] <= q_head.cmd.value;
         end
      end
      if (load) begin
         out_value_ff  <= out_value_in;
         out_way_ff    <= out_way_in;
         out_refill_ff <= out_refill_in;
         out_done_ff   <= out_done_in;
         out_dummy_ff  <= out_dummy_in;
         out_lob_ff    <= out_lob_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_value     = out_value_ff;
   assign rsp_from_way      = out_way_ff;
   assign rsp_refill_needed = out_refill_ff;
   assign rsp_run_done      = out_done_ff;
   assign rsp_dummy_run     = out_dummy_ff;
   assign rsp_last_of_burst = out_lob_ff;

   a_emit_no_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> wait_ff == '0)
      else $error("emitting while a way still owes its head");

   a_valid_xor_wait: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & wait_ff) == '0)
      else $error("a way both holds a head and waits for one");

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (last_ff & ~valid_ff) == '0)
      else $error("end-of-run mark on a way without a live head");

   a_refill_ends_burst: assert property (@(posedge clock) disable iff (reset)
      load && out_refill_in |=> state_ff == ST_IDLE && out_lob_ff)
      else $error("refill request did not close the burst");

endmodule

// File: hdl/kway_run_merger_core.sv
// K-way run merger top level: front decoder, command queue and merge engine.
// A head that completes the waiting set passes the queue entry, the head registers and the
// output register before its first result; a burst then adds one result per cycle through
// the minimum tree while rsp_stall is low. A start, or a head that leaves a way waiting,
// is taken in ST_IDLE; one that completes the set holds the engine in ST_EMIT for its burst.
// Reset clears control state and the valid, end-of-run and waiting marks, not head values.
module kway_run_merger_core #(
   parameter int MAX_WAYS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [kwrm_pkg::MASK_W-1:0]         req_active_mask,
   input  logic [kwrm_pkg::WAY_W-1:0]          req_way,
   input  logic signed [kwrm_pkg::VALUE_W-1:0] req_head_value,
   input  logic                                req_last_in_run,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [kwrm_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [kwrm_pkg::WAY_W-1:0]          rsp_from_way,
   output logic                                rsp_refill_needed,
   output logic                                rsp_run_done,
   output logic                                rsp_dummy_run,
   output logic                                rsp_last_of_burst
);
   import kwrm_pkg::*;

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       q_pop;

   kwrm_front #(
      .MAX_WAYS (MAX_WAYS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_active_mask (req_active_mask),
      .req_way         (req_way),
      .req_head_value  (req_head_value),
      .req_last_in_run (req_last_in_run),
      .q_full          (q_full),
      .q_push          (q_push)
   );

   kwrm_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   kwrm_back #(
      .MAX_WAYS (MAX_WAYS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_value     (rsp_out_value),
      .rsp_from_way      (rsp_from_way),
      .rsp_refill_needed (rsp_refill_needed),
      .rsp_run_done      (rsp_run_done),
      .rsp_dummy_run     (rsp_dummy_run),
      .rsp_last_of_burst (rsp_last_of_burst)
   );

endmodule
